// File: src/bpr_pkg.sv
// ---------------------------------------------------------------------------
// BMP pixel converter package
// Shared types, codes and helper functions for the pixel to RGBA converter.
// ---------------------------------------------------------------------------
package bpr_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int QUEUE_DEPTH       = 4;
    localparam int NUM_CH            = 4;
    localparam int Q_BITS            = 8;
    localparam int DIV_W             = 33;
    localparam int REM_W             = DIV_W + Q_BITS;
    localparam int ADDR_W            = 5;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    typedef enum logic [2:0] {
        MODE_PAL8     = 3'd0,
        MODE_RGB24    = 3'd1,
        MODE_ARGB32   = 3'd2,
        MODE_RGB555   = 3'd3,
        MODE_BITFIELD = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        REG_SOURCE_MODE   = 3'd0,
        REG_RGBA_ORDER    = 3'd1,
        REG_RED_MASK      = 3'd2,
        REG_GREEN_MASK    = 3'd3,
        REG_BLUE_MASK     = 3'd4,
        REG_ALPHA_MASK    = 3'd5,
        REG_ALPHA_ENABLED = 3'd6
    } t_reg;

    typedef enum logic {
        OP_CONVERT   = 1'b0,
        OP_PAL_WRITE = 1'b1
    } t_op;

    typedef struct packed {
        logic        command;
        logic [31:0] pixel_bits;
        logic        first_of_image;
        logic [7:0]  palette_index;
        logic [23:0] palette_color;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte0;
        logic [7:0] out_byte1;
        logic [7:0] out_byte2;
        logic [7:0] out_byte3;
        logic       alpha_seen;
    } t_out_item;

    typedef struct packed {
        t_op         op;
        logic [31:0] pixel;
        logic        first;
        logic [7:0]  pal_index;
        logic [23:0] pal_color;
    } t_qent;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic [2:0]                   mode;
        logic                         order;
        logic                         alpha_en;
        logic [NUM_CH-1:0][31:0]      mask;
        logic [NUM_CH-1:0][4:0]       tz;
        logic [NUM_CH-1:0][DIV_W-1:0] d2;
        logic [NUM_CH-1:0]            zero;
    } t_cfg;

    function automatic logic [4:0] f_low_bit(input logic [31:0] m);
        logic [4:0] pos;
        pos = '0;
        for (int i = 31; i >= 0; i--) begin
            if (m[i]) begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

    function automatic logic [4:0] f_high_bit(input logic [31:0] m);
        logic [4:0] pos;
        pos = '0;
        for (int i = 0; i < 32; i++) begin
            if (m[i]) begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

    function automatic logic [DIV_W-1:0] f_divisor(input logic [31:0] m);
        logic [5:0]  span;
        logic [32:0] ones;
        span = 6'(f_high_bit(m)) - 6'(f_low_bit(m)) + 6'd1;
        ones = (33'd1 << span) - 33'd1;
        return {ones[31:0], 1'b0};
    endfunction

endpackage

// File: src/bpr_cfg.sv
// ---------------------------------------------------------------------------
// Configuration registers
// APB register file; derives the mask shift and divisor when a mask is written.
// ---------------------------------------------------------------------------
module bpr_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpr_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output bpr_pkg::t_cfg               o_cfg
);
    logic                                          w_wr;
    logic [2:0]                                    w_idx;
    logic [2:0]                                    r_mode;
    logic                                          r_order;
    logic                                          r_alpha_en;
    logic [bpr_pkg::NUM_CH-1:0][31:0]              r_mask;
    logic [bpr_pkg::NUM_CH-1:0][4:0]               r_tz;
    logic [bpr_pkg::NUM_CH-1:0][bpr_pkg::DIV_W-1:0] r_d2;
    logic [bpr_pkg::NUM_CH-1:0]                    r_zero;
    logic [1:0]                                    w_ch;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];
    assign w_ch   = 2'(w_idx - 3'(bpr_pkg::REG_RED_MASK));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 3'(bpr_pkg::MODE_RGB24);
            r_order    <= 1'b0;
            r_alpha_en <= 1'b0;
            r_mask     <= '0;
            r_tz       <= '0;
            r_d2       <= '0;
            r_zero     <= '1;
        end else if (w_wr) begin
            unique case (w_idx)
                bpr_pkg::REG_SOURCE_MODE:   r_mode <= pwdata[2:0];
                bpr_pkg::REG_RGBA_ORDER:    r_order <= pwdata[0];
                bpr_pkg::REG_ALPHA_ENABLED: r_alpha_en <= pwdata[0];
                bpr_pkg::REG_RED_MASK, bpr_pkg::REG_GREEN_MASK,
                bpr_pkg::REG_BLUE_MASK, bpr_pkg::REG_ALPHA_MASK: begin
                    r_mask[w_ch] <= pwdata;
                    r_tz[w_ch]   <= bpr_pkg::f_low_bit(pwdata);
                    r_d2[w_ch]   <= bpr_pkg::f_divisor(pwdata);
                    r_zero[w_ch] <= (pwdata == 32'd0);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            bpr_pkg::REG_SOURCE_MODE:   prdata = {29'd0, r_mode};
            bpr_pkg::REG_RGBA_ORDER:    prdata = {31'd0, r_order};
            bpr_pkg::REG_ALPHA_ENABLED: prdata = {31'd0, r_alpha_en};
            bpr_pkg::REG_RED_MASK, bpr_pkg::REG_GREEN_MASK,
            bpr_pkg::REG_BLUE_MASK, bpr_pkg::REG_ALPHA_MASK: prdata = r_mask[w_ch];
            default: prdata = 32'd0;
        endcase
    end

    always_comb begin
        o_cfg.mode     = r_mode;
        o_cfg.order    = r_order;
        o_cfg.alpha_en = r_alpha_en;
        o_cfg.mask     = r_mask;
        o_cfg.tz       = r_tz;
        o_cfg.d2       = r_d2;
        o_cfg.zero     = r_zero;
    end
endmodule

// File: src/bpr_front.sv
// ---------------------------------------------------------------------------
// Front stage
// Accepts input items, classifies them and drops palette writes out of range.
// ---------------------------------------------------------------------------
module bpr_front #(
    parameter int PALETTE_DEPTH = bpr_pkg::PALETTE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  bpr_pkg::t_in_item i_in_item,
    output logic              o_in_stall,
    input  bpr_pkg::t_qstat   i_qstat,
    output logic              o_push,
    output bpr_pkg::t_qent    o_push_ent
);
    logic           r_valid;
    bpr_pkg::t_qent r_ent;
    logic           w_accept;
    logic           w_keep;
    bpr_pkg::t_qent n_ent;

    assign o_in_stall = r_valid && i_qstat.full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_qstat.full;
    assign o_push_ent = r_ent;

    always_comb begin
        n_ent.op        = i_in_item.command ? bpr_pkg::OP_PAL_WRITE : bpr_pkg::OP_CONVERT;
        n_ent.pixel     = i_in_item.pixel_bits;
        n_ent.first     = i_in_item.first_of_image;
        n_ent.pal_index = i_in_item.palette_index;
        n_ent.pal_color = i_in_item.palette_color;
        w_keep = !i_in_item.command
              || ({1'b0, i_in_item.palette_index} < 9'(PALETTE_DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= w_keep;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ent <= n_ent;
        end
    end
endmodule

// File: src/bpr_queue.sv
// ---------------------------------------------------------------------------
// Decoupling queue
// Short FIFO between the front stage and the conversion pipeline.
// ---------------------------------------------------------------------------
module bpr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bpr_pkg::t_qent  i_push_ent,
    input  logic            i_pop,
    output bpr_pkg::t_qent  o_head,
    output bpr_pkg::t_qstat o_qstat
);
    localparam int QW = $clog2(bpr_pkg::QUEUE_DEPTH);

    bpr_pkg::t_qent r_mem [bpr_pkg::QUEUE_DEPTH];
    logic [QW-1:0]  r_wp;
    logic [QW-1:0]  r_rp;
    logic [QW:0]    r_cnt;

    assign o_head        = r_mem[r_rp];
    assign o_qstat.full  = (r_cnt == (QW+1)'(bpr_pkg::QUEUE_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= QW'(r_wp + 1'b1);
            end
            if (i_pop) begin
                r_rp <= QW'(r_rp + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_ent;
        end
    end
endmodule

// File: src/bpr_back.sv
// ---------------------------------------------------------------------------
// Conversion pipeline
// Palette memory, alpha flag, rounded field scaling and output register.
// ---------------------------------------------------------------------------
module bpr_back #(
    parameter int PALETTE_DEPTH = bpr_pkg::PALETTE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bpr_pkg::t_cfg      i_cfg,
    input  bpr_pkg::t_qent     i_head,
    input  bpr_pkg::t_qstat    i_qstat,
    output logic               o_pop,
    output logic               o_out_valid,
    output bpr_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);
    localparam int IW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int NC = bpr_pkg::NUM_CH;
    localparam int QB = bpr_pkg::Q_BITS;
    localparam int RW = bpr_pkg::REM_W;

    typedef struct packed {
        logic                     valid;
        logic [NC-1:0][RW-1:0]    rem;
        logic [NC-1:0][QB-1:0]    quo;
        logic [31:0]              direct;
        logic [23:0]              pal;
        logic                     alpha_seen;
    } t_stage;

    logic [23:0]        r_pal_mem [PALETTE_DEPTH];
    logic               r_pal_vld [PALETTE_DEPTH];
    logic [23:0]        r_pal_rd;
    logic               r_pal_ok;
    logic               r_flag;
    logic               n_flag;
    logic               w_adv;
    logic               w_wr;
    logic               w_rd_in;
    logic [IW-1:0]      w_wr_idx;
    logic [IW-1:0]      w_rd_idx;
    t_stage             n_s0;
    t_stage             r_st [QB+1];
    t_stage             w_src [QB];
    t_stage             w_last;
    logic [7:0]         w_r;
    logic [7:0]         w_g;
    logic [7:0]         w_b;
    logic [7:0]         w_a;
    logic               r_out_valid;
    bpr_pkg::t_out_item r_out_item;
    bpr_pkg::t_out_item n_out_item;

    assign w_adv       = !r_out_valid || !i_out_stall;
    assign o_pop       = w_adv && !i_qstat.empty;
    assign w_wr        = o_pop && (i_head.op == bpr_pkg::OP_PAL_WRITE);
    assign w_wr_idx    = IW'(i_head.pal_index);
    assign w_rd_idx    = IW'(i_head.pixel[7:0]);
    assign w_rd_in     = ({1'b0, i_head.pixel[7:0]} < 9'(PALETTE_DEPTH));
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_pal_mem[w_wr_idx] <= i_head.pal_color;
        end
        if (o_pop) begin
            r_pal_rd <= r_pal_mem[w_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PALETTE_DEPTH; i++) begin
                r_pal_vld[i] <= 1'b0;
            end
        end else if (w_wr) begin
            r_pal_vld[w_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pal_ok <= w_rd_in && r_pal_vld[w_rd_idx];
        end
    end

    always_comb begin
        logic [31:0] v;
        logic [31:0] d;
        n_flag = (i_head.first ? 1'b0 : r_flag)
               | ((i_cfg.mode == 3'(bpr_pkg::MODE_ARGB32)) && (i_head.pixel[31:24] != 8'd0));
        n_s0            = '0;
        n_s0.valid      = o_pop && (i_head.op == bpr_pkg::OP_CONVERT);
        n_s0.alpha_seen = n_flag;
        for (int c = 0; c < NC; c++) begin
            v = (i_head.pixel & i_cfg.mask[c]) >> i_cfg.tz[c];
            d = i_cfg.d2[c][32:1];
            n_s0.rem[c] = ({9'd0, v} << 9) - ({9'd0, v} << 1) + {9'd0, d};
        end
        unique case (i_cfg.mode)
            bpr_pkg::MODE_RGB24:  n_s0.direct = {i_head.pixel[23:0], 8'hFF};
            bpr_pkg::MODE_ARGB32: n_s0.direct = {i_head.pixel[23:0], i_head.pixel[31:24]};
            bpr_pkg::MODE_RGB555: n_s0.direct = {
                i_head.pixel[14:10], i_head.pixel[14:12],
                i_head.pixel[9:5],   i_head.pixel[9:7],
                i_head.pixel[4:0],   i_head.pixel[4:2], 8'hFF};
            default: n_s0.direct = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else if (o_pop && (i_head.op == bpr_pkg::OP_CONVERT)) begin
            r_flag <= n_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st[0].valid <= 1'b0;
        end else if (w_adv) begin
            r_st[0].valid <= n_s0.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_st[0].rem        <= n_s0.rem;
            r_st[0].quo        <= n_s0.quo;
            r_st[0].direct     <= n_s0.direct;
            r_st[0].pal        <= n_s0.pal;
            r_st[0].alpha_seen <= n_s0.alpha_seen;
        end
    end

    always_comb begin
        w_src[0]     = r_st[0];
        w_src[0].pal = r_pal_ok ? r_pal_rd : 24'd0;
    end

    for (genvar j = 1; j < QB; j++) begin : g_src
        assign w_src[j] = r_st[j];
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int K = QB - 1 - j;
        t_stage n_st;

        always_comb begin
            logic [RW-1:0] sub;
            n_st = w_src[j];
            for (int c = 0; c < NC; c++) begin
                sub = {{(RW - bpr_pkg::DIV_W){1'b0}}, i_cfg.d2[c]} << K;
                if (w_src[j].rem[c] >= sub) begin
                    n_st.rem[c]    = w_src[j].rem[c] - sub;
                    n_st.quo[c][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[j+1].valid <= 1'b0;
            end else if (w_adv) begin
                r_st[j+1].valid <= n_st.valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_st[j+1].rem        <= n_st.rem;
                r_st[j+1].quo        <= n_st.quo;
                r_st[j+1].direct     <= n_st.direct;
                r_st[j+1].pal        <= n_st.pal;
                r_st[j+1].alpha_seen <= n_st.alpha_seen;
            end
        end
    end

    assign w_last = r_st[QB];

    always_comb begin
        unique case (i_cfg.mode)
            bpr_pkg::MODE_PAL8: begin
                w_r = w_last.pal[23:16];
                w_g = w_last.pal[15:8];
                w_b = w_last.pal[7:0];
                w_a = 8'hFF;
            end
            bpr_pkg::MODE_RGB24, bpr_pkg::MODE_ARGB32, bpr_pkg::MODE_RGB555: begin
                w_r = w_last.direct[31:24];
                w_g = w_last.direct[23:16];
                w_b = w_last.direct[15:8];
                w_a = w_last.direct[7:0];
            end
            bpr_pkg::MODE_BITFIELD: begin
                w_r = i_cfg.zero[bpr_pkg::CH_RED]   ? 8'd0 : w_last.quo[bpr_pkg::CH_RED];
                w_g = i_cfg.zero[bpr_pkg::CH_GREEN] ? 8'd0 : w_last.quo[bpr_pkg::CH_GREEN];
                w_b = i_cfg.zero[bpr_pkg::CH_BLUE]  ? 8'd0 : w_last.quo[bpr_pkg::CH_BLUE];
                w_a = (i_cfg.alpha_en && !i_cfg.zero[bpr_pkg::CH_ALPHA])
                    ? w_last.quo[bpr_pkg::CH_ALPHA] : 8'hFF;
            end
            default: begin
                w_r = 8'd0;
                w_g = 8'd0;
                w_b = 8'd0;
                w_a = 8'd0;
            end
        endcase
        n_out_item.out_byte0  = i_cfg.order ? w_r : w_b;
        n_out_item.out_byte1  = w_g;
        n_out_item.out_byte2  = i_cfg.order ? w_b : w_r;
        n_out_item.out_byte3  = w_a;
        n_out_item.alpha_seen = w_last.alpha_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_item <= n_out_item;
        end
    end
endmodule

// File: src/bmp_pixel_to_rgba_converter.sv
// ---------------------------------------------------------------------------
// BMP pixel to RGBA converter
// Converts one BMP source pixel per item into four bytes in BGRA or RGBA order.
// ---------------------------------------------------------------------------
// Input items arrive on i_in_valid / o_in_stall and carry either a pixel to
// convert or a palette entry to load. Each convert item gives one result item
// on o_out_valid / i_out_stall; palette writes give none.
// Users must write registers over the APB port only while the block is idle;
// the block itself does not enforce it. One item is taken per clock while
// o_in_stall is low. The edge that accepts an item loads the front register;
// one queue slot, the palette read stage, eight compare-subtract stages of
// the rounded field scaler and the output register follow.
// When the receiver stalls, the pipeline holds; the four-entry queue and the
// front register absorb further items until o_in_stall rises.
// Reset clears the alpha-seen flag, the queue, the pipeline and the palette
// valid bits, so every palette entry reads as black until it is written.
// Registers reset to rgb24 mode, BGRA order and zero masks.
// ---------------------------------------------------------------------------
module bmp_pixel_to_rgba_converter #(
    parameter int PALETTE_DEPTH = bpr_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  bpr_pkg::t_in_item          i_in_item,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output bpr_pkg::t_out_item         o_out_item,
    input  logic                       i_out_stall,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bpr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    bpr_pkg::t_cfg   w_cfg;
    bpr_pkg::t_qstat w_qstat;
    bpr_pkg::t_qent  w_push_ent;
    bpr_pkg::t_qent  w_head;
    logic            w_push;
    logic            w_pop;

    bpr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bpr_front #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_qstat    (w_qstat),
        .o_push     (w_push),
        .o_push_ent (w_push_ent)
    );

    bpr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_ent (w_push_ent),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_qstat    (w_qstat)
    );

    bpr_back #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_head      (w_head),
        .i_qstat     (w_qstat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("Item pushed into a full queue.");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("Item popped from an empty queue.");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> w_qstat.full)
        else $error("Input stalled while the queue has room.");
endmodule
